>>> sv/bse_pkg.sv
// bse_pkg: shared types, constants and helper functions for the bezier spline evaluator
// used by bse_mul, bezier_spline_evaluator_top, bse_checker and testbench; no dependencies
package bse_pkg;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENTS = 1'b1;

   // request kinds carried on tuser
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   // datapath widths
   localparam int PT_W   = 32;
   localparam int OUT_W  = 40;
   localparam int OP_W   = 38;
   localparam int MUL_W  = 21;
   localparam int PROD_W = 42;
   localparam int ACC_W  = 64;
   localparam int WGT_W  = 17;

   localparam logic [WGT_W-1:0] ONE_Q16 = 17'h10000;

   // six raw table slots of one axis
   typedef logic [5:0][PT_W-1:0] raw_pts_type;

   // binomial coefficient for degrees two to five
   function automatic logic [3:0] binom(input logic [2:0] m, input logic [2:0] k);
      logic [3:0] c;
      case ({m, k})
         6'o20, 6'o22: c = 4'd1;
         6'o21:        c = 4'd2;
         6'o30, 6'o33: c = 4'd1;
         6'o31, 6'o32: c = 4'd3;
         6'o40, 6'o44: c = 4'd1;
         6'o41, 6'o43: c = 4'd4;
         6'o42:        c = 4'd6;
         6'o50, 6'o55: c = 4'd1;
         6'o51, 6'o54: c = 4'd5;
         6'o52, 6'o53: c = 4'd10;
         default:      c = 4'd0;
      endcase
      return c;
   endfunction

   // segment point k (or forward difference k) from raw slots, with c2 rebuild
   function automatic logic signed [OP_W-1:0] pick_operand(input raw_pts_type r,
                                                           input logic tail,
                                                           input logic deriv,
                                                           input logic [2:0] k);
      logic signed [35:0] a0;
      logic signed [35:0] a1;
      logic signed [35:0] a2;
      logic signed [35:0] pt [6];
      logic signed [36:0] df [5];
      logic signed [OP_W-1:0] res;
      a0 = 36'($signed(r[0]));
      a1 = 36'($signed(r[1]));
      a2 = 36'($signed(r[2]));
      pt[0] = tail ? a2 : a0;
      pt[1] = tail ? (a2 <<< 1) - a1 : a1;
      pt[2] = tail ? (a2 <<< 2) - (a1 <<< 2) + a0 : a2;
      pt[3] = 36'($signed(r[3]));
      pt[4] = 36'($signed(r[4]));
      pt[5] = 36'($signed(r[5]));
      for (int i = 0; i < 5; i++) begin
         df[i] = 37'(pt[i+1]) - 37'(pt[i]);
      end
      case (k)
         3'd0: res = deriv ? OP_W'(df[0]) : OP_W'(pt[0]);
         3'd1: res = deriv ? OP_W'(df[1]) : OP_W'(pt[1]);
         3'd2: res = deriv ? OP_W'(df[2]) : OP_W'(pt[2]);
         3'd3: res = deriv ? OP_W'(df[3]) : OP_W'(pt[3]);
         3'd4: res = deriv ? OP_W'(df[4]) : OP_W'(pt[4]);
         3'd5: res = deriv ? '0 : OP_W'(pt[5]);
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

>>> sv/bse_ram.sv
// bse_ram: generic single write port, single read port ram with registered read
// no dependencies
module bse_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bse_mul.sv
// bse_mul: shared signed multiplier with registered product
// depends on bse_pkg for widths
module bse_mul (
   input  logic                               clock,
   input  logic signed [bse_pkg::MUL_W-1:0]   mul_a,
   input  logic signed [bse_pkg::MUL_W-1:0]   mul_b,
   output logic signed [bse_pkg::PROD_W-1:0]  mul_prod
);

   logic signed [bse_pkg::PROD_W-1:0] prod_ff;

   // one product per cycle
   always_ff @(posedge clock) begin
      prod_ff <= bse_pkg::PROD_W'(mul_a) * bse_pkg::PROD_W'(mul_b);
   end

   assign mul_prod = prod_ff;

endmodule

>>> sv/bezier_spline_evaluator_top.sv
// bezier_spline_evaluator_top: 2d cubic or quintic piecewise bezier evaluator
// load request: table written on accept, then acknowledged; one request at a time
// evaluate request: fetch six table slots, then for each of the m+1 terms multiply
// out its weight factor by factor, set up the operands and accumulate four partial
// products on the shared multiplier; m = degree (minus 1 for derivative)
// reset (synchronous, active high) clears control state; table stays undefined
module bezier_spline_evaluator_top #(
   parameter int MAX_POINTS   = 64,
   parameter int MAX_SEGMENTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // point_index[5:0], point_x[37:6], point_y[69:38], param_t[90:70], deriv_order[91]
   input  logic [95:0] req_tdata,
   // req_type[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // curve_x[39:0], curve_y[79:40]
   output logic [79:0] rsp_tdata,
   // is_evaluation[0]
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [bse_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [4:0]  csr_wdata
);

   localparam int AW      = $clog2(MAX_POINTS);
   localparam int SEG_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int NSEG_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int IDX_RAW = $clog2(3 * MAX_SEGMENTS + 3);
   localparam int IDX_W   = (IDX_RAW > AW) ? IDX_RAW : AW;
   localparam int TW      = ((NSEG_W + 16) > 21) ? (NSEG_W + 16) : 21;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_WMUL  = 3'd2;
   localparam logic [2:0] ST_WUPD  = 3'd3;
   localparam logic [2:0] ST_SETUP = 3'd4;
   localparam logic [2:0] ST_PMUL  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // request fields
   logic [5:0]  in_index;
   logic [31:0] in_x;
   logic [31:0] in_y;
   logic [20:0] in_t;
   logic        in_deriv;
   assign in_index = req_tdata[5:0];
   assign in_x     = req_tdata[37:6];
   assign in_y     = req_tdata[69:38];
   assign in_t     = req_tdata[90:70];
   assign in_deriv = req_tdata[91];

   // control and datapath registers
   logic [2:0]  state_ff;
   logic        degree_ff;
   logic [4:0]  segcnt_ff;
   logic        load_ff;
   logic        deriv_ff;
   logic        quint_ff;
   logic [SEG_W-1:0] seg_ff;
   logic [16:0] frac_ff;
   logic [2:0]  m_ff;
   logic [2:0]  j_ff;
   logic        rd_ok_ff;
   bse_pkg::raw_pts_type rx_ff;
   bse_pkg::raw_pts_type ry_ff;
   logic [2:0]  k_ff;
   logic [2:0]  i_ff;
   logic [2:0]  q_ff;
   logic [bse_pkg::WGT_W-1:0] w_ff;
   logic [19:0] wc_ff;
   logic signed [bse_pkg::OP_W-1:0]  opx_ff;
   logic signed [bse_pkg::OP_W-1:0]  opy_ff;
   logic signed [bse_pkg::ACC_W-1:0] accx_ff;
   logic signed [bse_pkg::ACC_W-1:0] accy_ff;
   logic        rsp_valid_ff;
   logic        rsp_eval_ff;
   logic [bse_pkg::OUT_W-1:0] rsp_x_ff;
   logic [bse_pkg::OUT_W-1:0] rsp_y_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= 1'b0;
         segcnt_ff <= 5'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            bse_pkg::CSR_DEGREE:   degree_ff <= csr_wdata[0];
            bse_pkg::CSR_SEGMENTS: segcnt_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // parameter clamp, segment and fraction split
   logic [NSEG_W-1:0] nseg;
   logic [TW-1:0]     tlim;
   logic [TW-1:0]     tcl;
   logic [SEG_W-1:0]  seg_in;
   logic [16:0]       frac_in;
   always_comb begin
      if (segcnt_ff == 5'd0) begin
         nseg = NSEG_W'(1);
      end else if (32'(segcnt_ff) > MAX_SEGMENTS) begin
         nseg = NSEG_W'(MAX_SEGMENTS);
      end else begin
         nseg = NSEG_W'(segcnt_ff);
      end
      tlim = TW'(nseg) << 16;
      tcl  = (TW'(in_t) > tlim) ? tlim : TW'(in_t);
      if ((tcl >> 16) >= TW'(nseg)) begin
         seg_in  = SEG_W'(nseg - 1'b1);
         frac_in = bse_pkg::ONE_Q16;
      end else begin
         seg_in  = SEG_W'(tcl >> 16);
         frac_in = {1'b0, tcl[15:0]};
      end
   end

   // control point table, {y, x} per slot
   logic [IDX_W-1:0] rd_idx;
   logic [63:0]      ram_q;
   logic             ram_we;
   logic             req_fire;
   assign req_fire = req_tvalid && req_tready;
   assign ram_we   = req_fire && (req_tuser == bse_pkg::REQ_LOAD)
                     && (32'(in_index) < MAX_POINTS);
   assign rd_idx   = (IDX_W'(seg_ff) << 1) + IDX_W'(seg_ff) + IDX_W'(j_ff);

   bse_ram #(
      .WIDTH(64),
      .DEPTH(MAX_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(in_index)),
      .wr_data ({in_y, in_x}),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (ram_q)
   );

   // shared multiplier operand select
   logic signed [bse_pkg::MUL_W-1:0]  mul_a;
   logic signed [bse_pkg::MUL_W-1:0]  mul_b;
   logic signed [bse_pkg::PROD_W-1:0] mul_prod;
   logic [16:0] wfac;
   assign wfac = (i_ff < k_ff) ? frac_ff : 17'(bse_pkg::ONE_Q16 - frac_ff);

   always_comb begin
      unique case (state_ff)
         ST_WMUL: begin
            mul_a = {4'b0, w_ff};
            mul_b = {4'b0, wfac};
         end
         ST_PMUL: begin
            mul_a = {1'b0, wc_ff};
            case (q_ff)
               3'd0:    mul_b = {3'b0, opx_ff[17:0]};
               3'd1:    mul_b = {opx_ff[37], opx_ff[37:18]};
               3'd2:    mul_b = {3'b0, opy_ff[17:0]};
               3'd3:    mul_b = {opy_ff[37], opy_ff[37:18]};
               default: mul_b = '0;
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   bse_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   // final rounding, degree scaling for the derivative and saturation
   function automatic logic [bse_pkg::OUT_W-1:0] finish(
      input logic signed [bse_pkg::ACC_W-1:0] acc, input logic deriv, input logic quint);
      logic signed [47:0] r;
      logic signed [50:0] v;
      logic [bse_pkg::OUT_W-1:0] res;
      r = 48'((acc + 64'sd32768) >>> 16);
      v = 51'(r);
      if (deriv) begin
         v = quint ? v + (v <<< 2) : v + (v <<< 1);
      end
      if (v > 51'sd549755813887) begin
         res = 40'h7FFFFFFFFF;
      end else if (v < -51'sd549755813888) begin
         res = 40'h8000000000;
      end else begin
         res = v[39:0];
      end
      return res;
   endfunction

   logic signed [bse_pkg::ACC_W-1:0] prod_ext;
   logic        tail;
   logic        rsp_load;
   assign prod_ext = bse_pkg::ACC_W'(mul_prod);
   assign tail     = quint_ff && (seg_ff != '0);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  load_ff  <= (req_tuser == bse_pkg::REQ_LOAD);
                  deriv_ff <= in_deriv;
                  quint_ff <= degree_ff;
                  seg_ff   <= seg_in;
                  frac_ff  <= frac_in;
                  m_ff     <= degree_ff ? (in_deriv ? 3'd4 : 3'd5)
                                        : (in_deriv ? 3'd2 : 3'd3);
                  j_ff     <= 3'd0;
                  state_ff <= (req_tuser == bse_pkg::REQ_LOAD) ? ST_DONE : ST_FETCH;
               end
            end
            ST_FETCH: begin
               rd_ok_ff <= (32'(rd_idx) < MAX_POINTS);
               if (j_ff != 3'd0) begin
                  rx_ff[j_ff - 3'd1] <= rd_ok_ff ? ram_q[31:0]  : 32'd0;
                  ry_ff[j_ff - 3'd1] <= rd_ok_ff ? ram_q[63:32] : 32'd0;
               end
               j_ff <= j_ff + 3'd1;
               if (j_ff == 3'd6) begin
                  k_ff     <= 3'd0;
                  i_ff     <= 3'd0;
                  w_ff     <= bse_pkg::ONE_Q16;
                  accx_ff  <= '0;
                  accy_ff  <= '0;
                  state_ff <= ST_WMUL;
               end
            end
            ST_WMUL: begin
               state_ff <= ST_WUPD;
            end
            ST_WUPD: begin
               w_ff     <= bse_pkg::WGT_W'((mul_prod + 42'sd32768) >>> 16);
               i_ff     <= i_ff + 3'd1;
               state_ff <= (i_ff + 3'd1 == m_ff) ? ST_SETUP : ST_WMUL;
            end
            ST_SETUP: begin
               wc_ff    <= 20'(21'(w_ff) * 21'(bse_pkg::binom(m_ff, k_ff)));
               opx_ff   <= bse_pkg::pick_operand(rx_ff, tail, deriv_ff, k_ff);
               opy_ff   <= bse_pkg::pick_operand(ry_ff, tail, deriv_ff, k_ff);
               q_ff     <= 3'd0;
               state_ff <= ST_PMUL;
            end
            ST_PMUL: begin
               q_ff <= q_ff + 3'd1;
               // product of the previous issue lands here
               case (q_ff)
                  3'd1:    accx_ff <= accx_ff + prod_ext;
                  3'd2:    accx_ff <= accx_ff + (prod_ext <<< 18);
                  3'd3:    accy_ff <= accy_ff + prod_ext;
                  3'd4:    accy_ff <= accy_ff + (prod_ext <<< 18);
                  default: ;
               endcase
               if (q_ff == 3'd4) begin
                  if (k_ff == m_ff) begin
                     state_ff <= ST_DONE;
                  end else begin
                     k_ff     <= k_ff + 3'd1;
                     i_ff     <= 3'd0;
                     w_ff     <= bse_pkg::ONE_Q16;
                     state_ff <= ST_WMUL;
                  end
               end
            end
            ST_DONE: begin
               if (rsp_load) begin
                  rsp_eval_ff  <= !load_ff;
                  rsp_x_ff     <= load_ff ? '0 : finish(accx_ff, deriv_ff, quint_ff);
                  rsp_y_ff     <= load_ff ? '0 : finish(accy_ff, deriv_ff, quint_ff);
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_eval_ff;

`ifndef NO_ASSERTIONS
   // an accepted request always leaves idle
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted request did not start work");

   // load acknowledge carries zero data
   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_eval_ff) |-> rsp_tdata == '0)
      else $error("load acknowledge with nonzero data");

   // term counter stays within the degree
   a_term_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PMUL |-> k_ff <= m_ff)
      else $error("term counter beyond degree");

   // weight factor counter stays below the degree
   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WMUL || state_ff == ST_WUPD) |-> i_ff < m_ff)
      else $error("weight factor counter out of range");

   // fetch never runs past the last slot capture
   a_fetch_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FETCH |-> j_ff <= 3'd6)
      else $error("fetch counter overrun");
`endif

endmodule

>>> tb/bse_checker.sv
// bse_checker: watches the request and response streams of the bezier spline evaluator,
// predicts each response from its own control point table and compares field by field
// depends on bse_pkg for register indexes and request kinds
`timescale 1ns / 100ps

module bse_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [bse_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [4:0]  csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [39:0] cx;
      logic [39:0] cy;
      logic        is_eval;
   } curve_result_type;

   longint           pts_x [64];
   longint           pts_y [64];
   logic             quintic_mode;
   logic [4:0]       seg_limit;
   curve_result_type expected_curve_q [$];

   assign pending_count = expected_curve_q.size();

   function automatic longint round_q16(longint v);
      v += 32768;
      if (v >= 0) return v >>> 16;
      return -((-v + 65535) >>> 16);
   endfunction

   function automatic longint seg_pt(ref longint tab [64], input int s, input int k);
      int b;
      b = 3 * s;
      if (!quintic_mode || s == 0) return (b + k < 64) ? tab[b+k] : 0;
      if (k == 0) return tab[b+2];
      if (k == 1) return 2 * tab[b+2] - tab[b+1];
      if (k == 2) return 4 * tab[b+2] - 4 * tab[b+1] + tab[b];
      return (b + k < 64) ? tab[b+k] : 0;
   endfunction

   function automatic longint bernstein_wt(int m, int k, longint f);
      longint w;
      longint c;
      w = 65536;
      for (int i = 0; i < k; i++) w = (w * f + 32768) >>> 16;
      for (int i = k; i < m; i++) w = (w * (65536 - f) + 32768) >>> 16;
      c = 1;
      for (int i = 0; i < k; i++) c = c * (m - i) / (i + 1);
      return w * c;
   endfunction

   function automatic logic [39:0] curve_axis(ref longint tab [64], input int s,
                                              input longint f, input logic deriv);
      int     n;
      int     m;
      longint acc;
      longint p;
      n = quintic_mode ? 5 : 3;
      m = deriv ? n - 1 : n;
      acc = 0;
      for (int k = 0; k <= m; k++) begin
         p = seg_pt(tab, s, k);
         if (deriv) p = seg_pt(tab, s, k + 1) - p;
         acc += bernstein_wt(m, k, f) * p;
      end
      acc = round_q16(acc);
      if (deriv) acc *= n;
      if (acc > 64'sd549755813887) acc = 64'sd549755813887;
      if (acc < -64'sd549755813888) acc = -64'sd549755813888;
      return acc[39:0];
   endfunction

   task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
      $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
      fail_count++;
   endtask

   // predict on request accept, compare on response accept
   always @(posedge clock) begin
      curve_result_type exp_r;
      int               nseg;
      int               s;
      longint           t;
      longint           f;
      if (reset) begin
         quintic_mode <= 1'b0;
         seg_limit <= 5'd1;
         expected_curve_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == bse_pkg::CSR_DEGREE) quintic_mode <= csr_wdata[0];
            else seg_limit <= csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            exp_r = '0;
            if (req_tuser == bse_pkg::REQ_LOAD) begin
               pts_x[req_tdata[5:0]] = longint'($signed(req_tdata[37:6]));
               pts_y[req_tdata[5:0]] = longint'($signed(req_tdata[69:38]));
            end else begin
               nseg = (seg_limit == 0) ? 1 : (seg_limit > 16 ? 16 : seg_limit);
               t = req_tdata[90:70];
               if (t > (longint'(nseg) << 16)) t = longint'(nseg) << 16;
               s = t >>> 16;
               f = t & 16'hffff;
               if (s >= nseg) begin
                  s = nseg - 1;
                  f = 65536;
               end
               exp_r.cx = curve_axis(pts_x, s, f, req_tdata[91]);
               exp_r.cy = curve_axis(pts_y, s, f, req_tdata[91]);
               exp_r.is_eval = 1'b1;
            end
            expected_curve_q.push_back(exp_r);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_curve_q.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata[39:0], 40'd0);
            end else begin
               exp_r = expected_curve_q.pop_front();
               if (rsp_tdata[39:0] !== exp_r.cx)
                  report_mismatch("curve_x", rsp_tdata[39:0], exp_r.cx);
               if (rsp_tdata[79:40] !== exp_r.cy)
                  report_mismatch("curve_y", rsp_tdata[79:40], exp_r.cy);
               if (rsp_tuser !== exp_r.is_eval)
                  report_mismatch("is_evaluation", 40'(rsp_tuser), 40'(exp_r.is_eval));
            end
         end
      end
   end

   initial fail_count = 0;
endmodule

>>> tb/testbench.sv
// testbench: stimulus and verdict for bezier_spline_evaluator_top
// depends on bse_pkg, bezier_spline_evaluator_top and bse_checker
`timescale 1ns / 100ps

module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [bse_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [4:0]  csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   bit          calm_phase = 1'b0;

   bezier_spline_evaluator_top u_dut (.*);

   bse_checker u_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side stalls in random bursts
   initial begin
      int n;
      @(posedge clock);
      forever begin
         n = $urandom_range(1, 12);
         if (!calm_phase && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat (n) @(posedge clock);
      end
   end

   initial begin
      #20ms;
      $display("bezier_spline_evaluator_top test failed");
      $finish;
   end

   // valid stays high after accept until the next request or an explicit drop
   task automatic send_request(logic kind, logic [5:0] idx, logic [31:0] px, logic [31:0] py,
                               logic [20:0] t, logic deriv);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'b0, deriv, t, py, px, idx};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic load_point(logic [5:0] idx, logic [31:0] px, logic [31:0] py);
      send_request(bse_pkg::REQ_LOAD, idx, px, py, 21'($urandom), 1'($urandom));
   endtask

   task automatic evaluate(logic [20:0] t, logic deriv);
      send_request(bse_pkg::REQ_EVAL, 6'($urandom), $urandom, $urandom, t, deriv);
   endtask

   // wait for the block to drain, then write one register
   task automatic write_csr(logic [bse_pkg::CSR_IDX_W-1:0] idx, logic [4:0] val);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
         default: return $urandom;
      endcase
   endfunction

   // pick a parameter, with extra weight on segment boundaries and the clamp
   function automatic logic [20:0] rand_param(int nseg);
      case ($urandom_range(0, 5))
         0: return 21'h1fffff;
         1: return 21'(nseg << 16);
         2: return 21'($urandom_range(0, nseg) << 16);
         default: return 21'($urandom_range(0, (nseg << 16) - 1));
      endcase
   endfunction

   initial begin
      int deg;
      int nseg;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fill every slot so later reads never touch unwritten entries
      for (int i = 0; i < 64; i++) load_point(6'(i), rand_coord(), rand_coord());

      // directed: extremes, both degrees, clamp and end-of-range cases
      write_csr(bse_pkg::CSR_SEGMENTS, 5'd16);
      load_point(6'd63, 32'h7fffffff, 32'h80000000);
      load_point(6'd0, 32'h80000000, 32'h7fffffff);
      for (int d = 0; d < 2; d++) begin
         write_csr(bse_pkg::CSR_DEGREE, 5'(d));
         evaluate(21'd0, 1'b0);
         evaluate(21'd0, 1'b1);
         evaluate(21'h0ffff, 1'b0);
         evaluate(21'h100000, 1'b0);
         evaluate(21'h100000, 1'b1);
         evaluate(21'h1fffff, 1'b1);
         evaluate(21'h0f8000, 1'b0);
      end
      write_csr(bse_pkg::CSR_SEGMENTS, 5'd0);
      evaluate(21'h1fffff, 1'b0);
      write_csr(bse_pkg::CSR_SEGMENTS, 5'd31);
      evaluate(21'h1fffff, 1'b1);

      // random phases over several settings
      for (int ph = 0; ph < 12; ph++) begin
         deg = $urandom_range(0, 1);
         nseg = (ph < 2) ? 16 : $urandom_range(1, 16);
         if (ph == 3) nseg = 1;
         write_csr(bse_pkg::CSR_DEGREE, 5'(deg));
         write_csr(bse_pkg::CSR_SEGMENTS, 5'(nseg));
         if (ph == 11) calm_phase = 1'b1;
         for (int i = 0; i < 145; i++) begin
            if ($urandom_range(0, 3) == 0)
               load_point(6'($urandom), rand_coord(), rand_coord());
            else
               evaluate(rand_param(nseg), 1'($urandom));
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("bezier_spline_evaluator_top test passed");
      else
         $display("bezier_spline_evaluator_top test failed");
      $finish;
   end
endmodule

>>> sim.f
sv/bse_pkg.sv
sv/bse_ram.sv
sv/bse_mul.sv
sv/bezier_spline_evaluator_top.sv
tb/bse_checker.sv
tb/testbench.sv
